[hdl/stbs_pkg.sv]
package stbs_pkg;

   localparam int VALUE_W             = 32;
   localparam int OPCODE_W            = 2;
   localparam int STATUS_W            = 2;
   localparam int POS_W               = 10;
   localparam int DEFAULT_TABLE_DEPTH = 1024;

   localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_FOUND = 2'd2,
      ST_MISS  = 2'd3
   } status_type;

endpackage

[hdl/stbs_ram.sv]
module stbs_ram
   import stbs_pkg::*;
#(
   parameter int WIDTH = VALUE_W,
   parameter int DEPTH = DEFAULT_TABLE_DEPTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/sorted_table_binary_search.sv]
// Sorted table with binary search.
//
// Request channel (req_valid / req_stall) carries one word: an opcode and a
// signed 32-bit value. Clear empties the table, append inserts the value at
// its ascending place (after any equal entries), search probes the table
// with a classic binary search and reports the index of the first matching
// probe. Each request word gives exactly one response word (rsp_status,
// rsp_position) on the response channel (rsp_valid / rsp_stall).
//
// One word is worked on at a time; req_stall is high while it is busy.
// Clear, full append and the unused opcode go straight to the finish state.
// Search alternates a probe read and a compare, at most ceil(log2(n+1))
// probes on n entries. Append finds its place with the same probes (at most
// floor(log2(n)) + 1), moves each entry above it up with a read and a write,
// then writes the value. A stalled receiver can hold a finished result back.
//
// Reset empties the table at once (entry count to zero); no clearing pass.
// A finished response sits in an output register, so the next word is taken
// while rsp_stall holds the previous response back; a second result then
// waits until that register drains.
module sorted_table_binary_search
   import stbs_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OPCODE_W-1:0]        req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [POS_W-1:0]           rsp_position
);

   localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int COUNT_W = ADDR_W + 1;
   localparam logic [COUNT_W-1:0] DEPTH_C = COUNT_W'(TABLE_DEPTH);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_PROBE_RD  = 7'b0000010,
      S_PROBE_CMP = 7'b0000100,
      S_SHIFT_RD  = 7'b0001000,
      S_SHIFT_WR  = 7'b0010000,
      S_INSERT    = 7'b0100000,
      S_FINISH    = 7'b1000000
   } state_type;

   state_type                  state_ff, state_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [COUNT_W-1:0]         lo_ff, lo_in;
   logic [COUNT_W-1:0]         hi_ff, hi_in;
   logic [COUNT_W-1:0]         ptr_ff, ptr_in;
   logic [ADDR_W-1:0]          mid_ff, mid_in;
   logic                       search_ff, search_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;
   status_type                 res_status_ff, res_status_in;
   logic [ADDR_W-1:0]          res_pos_ff, res_pos_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]           rsp_position_ff, rsp_position_in;

   logic                       req_accept;
   logic                       out_free;
   logic [COUNT_W:0]           mid_sum;
   logic [COUNT_W-1:0]         mid_ext;
   logic [COUNT_W-1:0]         ptr_dec;
   logic                       key_lt;
   logic                       key_eq;
   logic                       go_right;
   logic [POS_W+ADDR_W-1:0]    pos_ext;

   logic                       ram_wr_en;
   logic [ADDR_W-1:0]          ram_wr_addr;
   logic [VALUE_W-1:0]         ram_wr_data;
   logic                       ram_rd_en;
   logic [ADDR_W-1:0]          ram_rd_addr;
   logic [VALUE_W-1:0]         ram_rd_data;

   stbs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Shared midpoint unit: search uses floor((lo + hi - 1) / 2) over the
   // inclusive range, place-finding uses floor((lo + hi) / 2) over [lo, hi).
   assign mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff} - {{COUNT_W{1'b0}}, search_ff};
   assign mid_ext = {1'b0, mid_ff};
   assign ptr_dec = ptr_ff - COUNT_W'(1);

   // Shared compare unit on the word just read back.
   assign key_lt   = $signed(ram_rd_data) < value_ff;
   assign key_eq   = $signed(ram_rd_data) == value_ff;
   assign go_right = search_ff ? key_lt : (key_lt || key_eq);

   // Mask the index to the width of the position field.
   assign pos_ext = {{POS_W{1'b0}}, res_pos_ff};

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      ptr_in          = ptr_ff;
      mid_in          = mid_ff;
      search_in       = search_ff;
      value_in        = value_ff;
      res_status_in   = res_status_ff;
      res_pos_in      = res_pos_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_position_in = rsp_position_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = lo_ff[ADDR_W-1:0];
      ram_wr_data     = value_ff;
      ram_rd_en       = 1'b0;
      ram_rd_addr     = mid_sum[ADDR_W:1];

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               value_in      = req_value;
               search_in     = (req_opcode == OP_SEARCH);
               lo_in         = '0;
               hi_in         = count_ff;
               res_status_in = ST_DONE;
               res_pos_in    = '0;
               state_in      = S_FINISH;
               if (req_opcode == OP_CLEAR) begin
                  count_in = '0;
               end else if (req_opcode == OP_APPEND) begin
                  if (count_ff >= DEPTH_C) begin
                     res_status_in = ST_FULL;
                  end else begin
                     state_in = S_PROBE_RD;
                  end
               end else if (req_opcode == OP_SEARCH) begin
                  state_in = S_PROBE_RD;
               end
            end
         end

         S_PROBE_RD: begin
            if (lo_ff < hi_ff) begin
               ram_rd_en = 1'b1;
               mid_in    = mid_sum[ADDR_W:1];
               state_in  = S_PROBE_CMP;
            end else if (search_ff) begin
               res_status_in = ST_MISS;
               state_in      = S_FINISH;
            end else begin
               ptr_in   = count_ff;
               state_in = S_SHIFT_RD;
            end
         end

         S_PROBE_CMP: begin
            if (search_ff && key_eq) begin
               res_status_in = ST_FOUND;
               res_pos_in    = mid_ff;
               state_in      = S_FINISH;
            end else begin
               if (go_right) begin
                  lo_in = mid_ext + COUNT_W'(1);
               end else begin
                  hi_in = mid_ext;
               end
               state_in = S_PROBE_RD;
            end
         end

         S_SHIFT_RD: begin
            // Move entries above the insertion place up by one, top first.
            if (ptr_ff > lo_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ptr_dec[ADDR_W-1:0];
               state_in    = S_SHIFT_WR;
            end else begin
               state_in = S_INSERT;
            end
         end

         S_SHIFT_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_ff[ADDR_W-1:0];
            ram_wr_data = ram_rd_data;
            ptr_in      = ptr_dec;
            state_in    = S_SHIFT_RD;
         end

         S_INSERT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = lo_ff[ADDR_W-1:0];
            ram_wr_data = value_ff;
            count_in    = count_ff + COUNT_W'(1);
            state_in    = S_FINISH;
         end

         S_FINISH: begin
            // Hold the result until the output register is free.
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_position_in = pos_ext[POS_W-1:0];
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      ptr_ff          <= ptr_in;
      mid_ff          <= mid_in;
      search_ff       <= search_in;
      value_ff        <= value_in;
      res_status_ff   <= res_status_in;
      res_pos_ff      <= res_pos_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;

   // The entry count never passes the table depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond table depth");

   // A clear empties the table by the next cycle.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_opcode == OP_CLEAR) |=> (count_ff == '0))
      else $error("clear did not empty the table");

   // A compare always follows the read that fetched its operand.
   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE_CMP) |-> $past(state_ff == S_PROBE_RD))
      else $error("probe compare without a preceding read");

   // An insert only happens with room left in the table.
   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INSERT) |-> (count_ff < DEPTH_C))
      else $error("insert into a full table");

endmodule
